>>> rtl/efmt_pkg.sv
// ----------------------------------------------------------------------------
// efmt_pkg
// Shared types, constants and the CRC-8 byte function for the encoder
// frame multi-turn tracker.
// ----------------------------------------------------------------------------
package efmt_pkg;

	localparam int ANGLE_W    = 21;
	localparam int STATUS_W   = 3;
	localparam int TURN_OUT_W = 32;
	localparam int POS_W      = TURN_OUT_W + ANGLE_W;

	localparam logic [7:0]         CRC_POLY     = 8'h07;
	localparam logic [7:0]         CRC_INIT     = 8'h00;
	localparam logic [ANGLE_W-1:0] THRESH_RESET = 21'd1677721;

	// one received frame after the CRC check
	typedef struct packed {
		logic                ok;
		logic [ANGLE_W-1:0]  angle;
		logic [STATUS_W-1:0] status;
	} frame_t;

	// one result beat
	typedef struct packed {
		logic                  crc_ok;
		logic [ANGLE_W-1:0]    angle;
		logic [STATUS_W-1:0]   sensor_status;
		logic [TURN_OUT_W-1:0] turn_count;
		logic [POS_W-1:0]      multi_turn_position;
	} result_t;

	// MSB-first CRC-8, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/efmt_crc_check.sv
// ----------------------------------------------------------------------------
// efmt_crc_check
// Checks CRC-8 over the three data bytes and unpacks angle and status.
// ----------------------------------------------------------------------------
module efmt_crc_check (
	input  logic [7:0]      angle_high_byte,
	input  logic [7:0]      angle_mid_byte,
	input  logic [7:0]      angle_low_status_byte,
	input  logic [7:0]      check_byte,
	output efmt_pkg::frame_t frame
);

	logic [7:0] crc0;
	logic [7:0] crc1;
	logic [7:0] crc2;

	always_comb begin
		crc0 = efmt_pkg::crc8_byte(efmt_pkg::CRC_INIT, angle_high_byte);
		crc1 = efmt_pkg::crc8_byte(crc0, angle_mid_byte);
		crc2 = efmt_pkg::crc8_byte(crc1, angle_low_status_byte);
	end

	assign frame.ok     = (crc2 == check_byte);
	assign frame.angle  = {angle_high_byte, angle_mid_byte, angle_low_status_byte[7:3]};
	assign frame.status = angle_low_status_byte[2:0];

endmodule

>>> rtl/efmt_turn_track.sv
// ----------------------------------------------------------------------------
// efmt_turn_track
// Holds angle, status and turn counter; counts a turn wrap when the angle
// jumps by more than the threshold. Failed frames leave all state alone.
// ----------------------------------------------------------------------------
module efmt_turn_track #(
	parameter int TURN_COUNT_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             upd,
	input  efmt_pkg::frame_t                 frame,
	input  logic [efmt_pkg::ANGLE_W-1:0]     threshold,
	output efmt_pkg::result_t                res
);

	localparam int EXT_W = (TURN_COUNT_WIDTH > efmt_pkg::TURN_OUT_W) ?
		TURN_COUNT_WIDTH : efmt_pkg::TURN_OUT_W;

	logic [efmt_pkg::ANGLE_W-1:0]  base_angle_q;
	logic                          have_prev_q;
	logic [efmt_pkg::ANGLE_W-1:0]  angle_q;
	logic [efmt_pkg::STATUS_W-1:0] status_q;
	logic [TURN_COUNT_WIDTH-1:0]   turns_q;

	logic [efmt_pkg::ANGLE_W-1:0]  prev_eff;
	logic [efmt_pkg::ANGLE_W-1:0]  jump_up;
	logic [efmt_pkg::ANGLE_W-1:0]  jump_dn;
	logic                          wrap_dec;
	logic                          wrap_inc;
	logic [TURN_COUNT_WIDTH-1:0]   turns_nxt;
	logic [efmt_pkg::ANGLE_W-1:0]  angle_nxt;
	logic [efmt_pkg::STATUS_W-1:0] status_nxt;
	logic [EXT_W-1:0]              turns_ext;

	always_comb begin
		prev_eff = have_prev_q ? base_angle_q : frame.angle;
		jump_up  = frame.angle - prev_eff;
		jump_dn  = prev_eff - frame.angle;
		wrap_dec = (frame.angle > prev_eff) && (jump_up > threshold);
		wrap_inc = (prev_eff > frame.angle) && (jump_dn > threshold);

		turns_nxt  = turns_q;
		angle_nxt  = angle_q;
		status_nxt = status_q;
		if (frame.ok) begin
			angle_nxt  = frame.angle;
			status_nxt = frame.status;
			if (wrap_dec) begin
				turns_nxt = turns_q - TURN_COUNT_WIDTH'(1);
			end else if (wrap_inc) begin
				turns_nxt = turns_q + TURN_COUNT_WIDTH'(1);
			end
		end

		turns_ext = EXT_W'($signed(turns_nxt));
	end

	assign res.crc_ok              = frame.ok;
	assign res.angle               = angle_nxt;
	assign res.sensor_status       = status_nxt;
	assign res.turn_count          = turns_ext[efmt_pkg::TURN_OUT_W-1:0];
	assign res.multi_turn_position = {turns_ext[efmt_pkg::TURN_OUT_W-1:0], angle_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_angle_q <= '0;
			have_prev_q  <= 1'b0;
			angle_q      <= '0;
			status_q     <= '0;
			turns_q      <= '0;
		end else if (upd && frame.ok) begin
			base_angle_q <= frame.angle;
			have_prev_q  <= 1'b1;
			angle_q      <= angle_nxt;
			status_q     <= status_nxt;
			turns_q      <= turns_nxt;
		end
	end

endmodule

>>> rtl/encoder_frame_multiturn_tracker_unit.sv
// ----------------------------------------------------------------------------
// encoder_frame_multiturn_tracker_unit
// CRC-8 checked absolute-encoder frame decoder with multi-turn counting.
// ----------------------------------------------------------------------------
// One input beat is one frame; one result beat follows per frame. A frame is
// held in the frame register, then loaded into the output register once that
// is free. A new frame is taken every cycle while the output is not stalled:
// the frame register feeds a single pass of CRC check, wrap compare and turn
// update into the result register; the turn state updates at the same edge.
// Frames failing CRC report crc_ok low with the held values. The user must
// write the wrap threshold through cfg_we/cfg_wdata while idle (not enforced).
module encoder_frame_multiturn_tracker_unit #(
	parameter int TURN_COUNT_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [20:0]   cfg_wdata,     // wrap_threshold
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// angle_high_byte, angle_mid_byte, angle_low_status_byte, check_byte
	input  logic [31:0]   s_axis_tdata,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// angle, sensor_status, turn_count, multi_turn_position, zero pad
	output logic [111:0]  m_axis_tdata,
	output logic          m_axis_tuser   // crc_ok
);

	logic [efmt_pkg::ANGLE_W-1:0] wrap_thresh_q;
	logic                         valid_s1;
	logic [31:0]                  data_s1;
	logic                         valid_s2;
	efmt_pkg::result_t            res_s2;
	efmt_pkg::frame_t             frame;
	efmt_pkg::result_t            res;
	logic                         load_out;

	assign load_out      = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_thresh_q <= efmt_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			wrap_thresh_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (load_out) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
		if (load_out) begin
			res_s2 <= res;
		end
	end

	efmt_crc_check u_crc (
		.angle_high_byte       (data_s1[7:0]),
		.angle_mid_byte        (data_s1[15:8]),
		.angle_low_status_byte (data_s1[23:16]),
		.check_byte            (data_s1[31:24]),
		.frame                 (frame)
	);

	efmt_turn_track #(
		.TURN_COUNT_WIDTH (TURN_COUNT_WIDTH)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (load_out),
		.frame     (frame),
		.threshold (wrap_thresh_q),
		.res       (res)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.crc_ok;
	assign m_axis_tdata  = {3'b000, res_s2.multi_turn_position, res_s2.turn_count,
		res_s2.sensor_status, res_s2.angle};

endmodule
